### rtl/salc_pkg.sv
// Shared types and constants for the set-associative LRU cache tag store.
// No dependencies; imported by the interfaces, the core and salc_lookup.
package salc_pkg;

   typedef enum logic [1:0] {
      FUNC_LOAD   = 2'd0,
      FUNC_STORE  = 2'd1,
      FUNC_MODIFY = 2'd2,
      FUNC_FETCH  = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_FILL  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_LOOK2
   } state_type;

   localparam int CNT_W      = 32;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   typedef logic [CNT_W-1:0] count_type;

   localparam logic [1:0] REG_SET_BITS   = 2'd0;
   localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
   localparam logic [1:0] REG_WAYS       = 2'd2;

endpackage

### rtl/salc_ifs.sv
// Valid/ready channel interfaces: access requests in, lookup results out.
// Depends on salc_pkg.
interface salc_req_if import salc_pkg::*; #(parameter int ADDR_WIDTH = 32);
   logic                  valid;
   logic                  ready;
   logic [1:0]            func;
   logic [ADDR_WIDTH-1:0] address;

   modport source (output valid, func, address, input ready);
   modport sink   (input valid, func, address, output ready);
endinterface

interface salc_rsp_if import salc_pkg::*;;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;
   count_type  hit_count;
   count_type  miss_count;
   count_type  evict_count;
   logic       last;

   modport source (output valid, outcome, hit_count, miss_count, evict_count, last,
                   input ready);
   modport sink   (input valid, outcome, hit_count, miss_count, evict_count, last,
                   output ready);
endinterface

### rtl/set_assoc_lru_cache_tags_core.sv
// Set-associative LRU cache tag store. After reset the set memory is cleared
// one row per cycle, all 2**MAX_SET_BITS rows (1024 by default), and no request
// is taken meanwhile; CSR writes are taken throughout. A load or store then
// reads the set row from the RAM and does one lookup, a modify two; each lookup
// compares tags, picks the line and writes the row back. The second lookup of
// a modify works on the row just computed. An instruction fetch is taken and
// gives no result. A result sits in an output register while the next request
// is taken. Depends on salc_pkg, salc_ifs, salc_ram and salc_lookup.
module set_assoc_lru_cache_tags_core import salc_pkg::*; #(
   parameter int MAX_SET_BITS = 10,
   parameter int MAX_WAYS     = 8,
   parameter int ADDR_WIDTH   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   salc_req_if.sink              req_chan,
   salc_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int TAG_W  = ADDR_WIDTH - 2;
   localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int EW     = 1 + RANK_W + TAG_W;
   localparam int ROW_W  = MAX_WAYS * EW;
   localparam int SETS   = 1 << MAX_SET_BITS;

   // ---------------- CSRs ----------------
   logic [3:0] set_bits_ff, set_bits_in;
   logic [4:0] block_bits_ff, block_bits_in;
   logic [3:0] ways_ff, ways_in;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            REG_SET_BITS:   set_bits_in   = csr_pwdata[3:0];
            REG_BLOCK_BITS: block_bits_in = csr_pwdata[4:0];
            REG_WAYS:       ways_in       = csr_pwdata[3:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         REG_SET_BITS:   csr_prdata = CSR_DATA_W'(set_bits_ff);
         REG_BLOCK_BITS: csr_prdata = CSR_DATA_W'(block_bits_ff);
         REG_WAYS:       csr_prdata = CSR_DATA_W'(ways_ff);
         default:        csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= 4'd4;
         block_bits_ff <= 5'd4;
         ways_ff       <= 4'd1;
      end else begin
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
      end
   end

   // ---------------- address split ----------------
   logic [4:0]              sb;
   logic [5:0]              sh;
   logic [4:0]              nw;
   logic [MAX_WAYS-1:0]     in_use;
   logic [TAG_W-1:0]        req_tag;
   logic [MAX_SET_BITS-1:0] req_set, set_mask;

   assign sb       = (5'(set_bits_ff) > 5'(MAX_SET_BITS)) ? 5'(MAX_SET_BITS)
                                                          : 5'(set_bits_ff);
   assign sh       = 6'(block_bits_ff) + 6'(sb);
   assign req_tag  = TAG_W'(req_chan.address >> sh);
   assign set_mask = ~({MAX_SET_BITS{1'b1}} << sb);
   assign req_set  = MAX_SET_BITS'(req_chan.address >> block_bits_ff) & set_mask;
   assign nw       = (ways_ff == 4'd0) ? 5'd1
                   : ((5'(ways_ff) > 5'(MAX_WAYS)) ? 5'(MAX_WAYS) : 5'(ways_ff));

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         in_use[w] = 5'(w) < nw;
      end
   end

   // ---------------- control ----------------
   state_type               state_ff, state_in;
   logic [MAX_SET_BITS-1:0] clr_ff, clr_in;
   logic [TAG_W-1:0]        tag_ff;
   logic [MAX_SET_BITS-1:0] set_ff;
   logic                    modify_ff;
   logic [ROW_W-1:0]        row_ff;
   logic                    req_acc, is_fetch, lk_go;

   logic                    mem_wr_en, mem_rd_en;
   logic [MAX_SET_BITS-1:0] mem_wr_addr;
   logic [ROW_W-1:0]        mem_wr_data, mem_rd_data;

   logic [ROW_W-1:0]        lk_row_in, lk_row_out;
   outcome_type             lk_outcome;

   assign is_fetch = (req_chan.func == FUNC_FETCH);
   assign req_acc  = req_chan.valid & req_chan.ready;
   assign lk_go    = ((state_ff == ST_LOOK) || (state_ff == ST_LOOK2))
                     & (~rsp_chan.valid | rsp_chan.ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: if (&clr_ff) state_in = ST_IDLE;
         ST_IDLE:  if (req_acc && !is_fetch) state_in = ST_LOOK;
         ST_LOOK:  if (lk_go) state_in = modify_ff ? ST_LOOK2 : ST_IDLE;
         ST_LOOK2: if (lk_go) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = 1'b0;
      mem_rd_en      = 1'b0;
      mem_wr_en      = 1'b0;
      mem_wr_addr    = set_ff;
      mem_wr_data    = lk_row_out;
      lk_row_in      = mem_rd_data;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            mem_rd_en      = req_chan.valid & ~is_fetch;
         end
         ST_LOOK: begin
            mem_wr_en = lk_go;
         end
         ST_LOOK2: begin
            mem_wr_en = lk_go;
            lk_row_in = row_ff;
         end
         default: ;
      endcase
   end

   assign clr_in = (state_ff == ST_CLEAR) ? clr_ff + 1'b1 : clr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         tag_ff    <= req_tag;
         set_ff    <= req_set;
         modify_ff <= (req_chan.func == FUNC_MODIFY);
      end
      if (lk_go) begin
         row_ff <= lk_row_out;
      end
   end

   salc_ram #(.WIDTH(ROW_W), .DEPTH(SETS)) u_set_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (req_set),
      .rd_data (mem_rd_data)
   );

   salc_lookup #(.MAX_WAYS(MAX_WAYS), .TAG_W(TAG_W), .RANK_W(RANK_W)) u_lookup (
      .row_in  (lk_row_in),
      .in_use  (in_use),
      .tag     (tag_ff),
      .row_out (lk_row_out),
      .outcome (lk_outcome)
   );

   // ---------------- totals and result register ----------------
   count_type   hits_ff, hits_in, misses_ff, misses_in, evicts_ff, evicts_in;
   logic        rsp_valid_ff, rsp_valid_in;
   outcome_type rsp_outcome_ff;
   count_type   rsp_hits_ff, rsp_misses_ff, rsp_evicts_ff;
   logic        rsp_last_ff;

   always_comb begin
      hits_in   = hits_ff;
      misses_in = misses_ff;
      evicts_in = evicts_ff;
      if (lk_go) begin
         if (lk_outcome == OUT_HIT) begin
            hits_in = (hits_ff == '1) ? hits_ff : hits_ff + 1'b1;
         end else begin
            misses_in = (misses_ff == '1) ? misses_ff : misses_ff + 1'b1;
         end
         if (lk_outcome == OUT_EVICT) begin
            evicts_in = (evicts_ff == '1) ? evicts_ff : evicts_ff + 1'b1;
         end
      end
   end

   assign rsp_valid_in = lk_go | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         hits_ff      <= '0;
         misses_ff    <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hits_ff      <= hits_in;
         misses_ff    <= misses_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lk_go) begin
         rsp_outcome_ff <= lk_outcome;
         rsp_hits_ff    <= hits_in;
         rsp_misses_ff  <= misses_in;
         rsp_evicts_ff  <= evicts_in;
         rsp_last_ff    <= (state_ff == ST_LOOK2) | ~modify_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.outcome     = rsp_outcome_ff;
   assign rsp_chan.hit_count   = rsp_hits_ff;
   assign rsp_chan.miss_count  = rsp_misses_ff;
   assign rsp_chan.evict_count = rsp_evicts_ff;
   assign rsp_chan.last        = rsp_last_ff;

`ifndef SYNTHESIS
   // second lookup of a modify finds the line the first one installed
   a_modify_second_hits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK2 && lk_go) |-> (lk_outcome == OUT_HIT))
      else $error("modify second lookup missed");

   a_evict_le_miss: assert property (@(posedge clock) disable iff (reset)
      evicts_ff <= misses_ff)
      else $error("evictions exceed misses");

   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (hits_ff >= $past(hits_ff)))
      else $error("hit total went backwards");

   a_rsp_from_lookup: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_LOOK || state_ff == ST_LOOK2))
      else $error("result raised outside a lookup");

   a_look2_after_look: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOK2) |-> $past(state_ff == ST_LOOK || state_ff == ST_LOOK2))
      else $error("second lookup without first");
`endif

endmodule

### rtl/salc_ram.sv
// Generic single-clock RAM, one write port and one read port, registered read.
// Read data holds while rd_en is low. No dependencies.
module salc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

### rtl/salc_lookup.sv
// Tag compare, victim choice and recency update for one set row.
// Row layout per way: {valid, rank, tag}. Depends on salc_pkg.
module salc_lookup import salc_pkg::*; #(
   parameter int MAX_WAYS = 8,
   parameter int TAG_W    = 30,
   parameter int RANK_W   = 3
) (
   input  logic [MAX_WAYS*(1+RANK_W+TAG_W)-1:0] row_in,
   input  logic [MAX_WAYS-1:0]                  in_use,
   input  logic [TAG_W-1:0]                     tag,
   output logic [MAX_WAYS*(1+RANK_W+TAG_W)-1:0] row_out,
   output outcome_type                          outcome
);

   localparam int EW    = 1 + RANK_W + TAG_W;
   localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

   logic [MAX_WAYS-1:0] valid_v, hit_v, free_v, vic_oh, age_v;
   logic [RANK_W-1:0]   rank_a [MAX_WAYS];
   logic [TAG_W-1:0]    tag_a  [MAX_WAYS];
   logic [WAY_W-1:0]    hit_idx, free_idx, vic_idx, sel_idx;
   logic [RANK_W-1:0]   sel_rank;
   logic                hit, fill;

   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         tag_a[w]   = row_in[w*EW +: TAG_W];
         rank_a[w]  = row_in[w*EW+TAG_W +: RANK_W];
         valid_v[w] = row_in[w*EW+EW-1];
         hit_v[w]   = in_use[w] & valid_v[w] & (tag_a[w] == tag);
         free_v[w]  = in_use[w] & ~valid_v[w];
      end
   end

   // victim: highest rank in use, lowest way wins a tie
   always_comb begin
      for (int w = 0; w < MAX_WAYS; w++) begin
         vic_oh[w] = in_use[w];
         for (int j = 0; j < MAX_WAYS; j++) begin
            if (j < w && in_use[j] && !(rank_a[w] > rank_a[j])) begin
               vic_oh[w] = 1'b0;
            end
            if (j > w && in_use[j] && (rank_a[j] > rank_a[w])) begin
               vic_oh[w] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hit_idx  = '0;
      free_idx = '0;
      vic_idx  = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (hit_v[w]) begin
            hit_idx = WAY_W'(w);
         end
         if (free_v[w]) begin
            free_idx = WAY_W'(w);
         end
         if (vic_oh[w]) begin
            vic_idx = WAY_W'(w);
         end
      end
   end

   assign hit      = |hit_v;
   assign fill     = ~hit & (|free_v);
   assign sel_idx  = hit ? hit_idx : (fill ? free_idx : vic_idx);
   assign sel_rank = rank_a[sel_idx];

   always_comb begin
      for (int i = 0; i < MAX_WAYS; i++) begin
         age_v[i] = in_use[i] & valid_v[i] & (WAY_W'(i) != sel_idx)
                    & (fill | (rank_a[i] < sel_rank)) & (rank_a[i] < RANK_MAX);
         if (WAY_W'(i) == sel_idx) begin
            row_out[i*EW +: EW] = {1'b1, {RANK_W{1'b0}}, tag};
         end else begin
            row_out[i*EW +: EW] = {valid_v[i],
                                   age_v[i] ? rank_a[i] + 1'b1 : rank_a[i],
                                   tag_a[i]};
         end
      end
   end

   always_comb begin
      if (hit) begin
         outcome = OUT_HIT;
      end else if (fill) begin
         outcome = OUT_FILL;
      end else begin
         outcome = OUT_EVICT;
      end
   end

endmodule
